@@ sv/rational_arithmetic_unit_assert.svh @@
// assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// implication checked on every clock unless reset
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rau_pkg.sv @@
`default_nettype none
package rau_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CntWidth  = 6;

   typedef logic [DataWidth-1:0] word_type;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD_SETUP,
      ST_GCD_DIV,
      ST_GCD_STEP,
      ST_RED_NUM,
      ST_RED_DEN,
      ST_MIXED,
      ST_MIX_DIV,
      ST_DONE
   } state_type;

   // divider operand selection
   typedef enum logic [1:0] {
      DSEL_GCD,
      DSEL_RED_NUM,
      DSEL_RED_DEN,
      DSEL_MIX
   } dsel_type;

   // controller to datapath
   typedef struct packed {
      logic     load;
      logic     mul;
      logic     sum;
      logic     gcd_setup;
      logic     div_start;
      dsel_type div_sel;
      logic     div_step;
      logic     gcd_step;
      logic     red_num;
      logic     red_den;
      logic     mix_eval;
      logic     mix_done;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic n_pos;
      logic b_zero;
      logic div_last;
      logic need_div;
   } status_type;

endpackage
`default_nettype wire

@@ sv/rau_ctrl.sv @@
`default_nettype none
module rau_ctrl import rau_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // new beat only once the previous result has gone or goes now
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.div_sel  = DSEL_GCD;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_GCD_SETUP;
         end
         ST_GCD_SETUP: begin
            if (sts.n_pos) begin
               cmd.gcd_setup = 1'b1;
               state_in      = ST_GCD_STEP;
            end else begin
               state_in = ST_MIXED;
            end
         end
         ST_GCD_STEP: begin
            if (sts.b_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_RED_NUM;
               state_in      = ST_RED_NUM;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_GCD;
               state_in      = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.gcd_step = 1'b1;
               state_in     = ST_GCD_STEP;
            end
         end
         ST_RED_NUM: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.red_num   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_RED_DEN;
               state_in      = ST_RED_DEN;
            end
         end
         ST_RED_DEN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.red_den = 1'b1;
               state_in    = ST_MIXED;
            end
         end
         ST_MIXED: begin
            cmd.mix_eval = 1'b1;
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_MIX;
               state_in      = ST_MIX_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MIX_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.mix_done = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/rau_dp.sv @@
`default_nettype none
module rau_dp import rau_pkg::*; #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   output status_type                    sts,
   input  wire logic [1:0]               req_func,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic signed [DataWidth-1:0]   rsp_res_num,
   output logic signed [DataWidth-1:0]   rsp_res_den,
   output logic signed [DataWidth-1:0]   rsp_whole_part,
   output logic signed [DataWidth-1:0]   rsp_frac_rem,
   output logic                          rsp_den_zero
);

   localparam int unsigned PW = 2 * OPERAND_WIDTH;

   func_type func_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   word_type n_ff, d_ff, whole_ff, rem_ff;
   logic     dz_ff;
   word_type ga_ff, gb_ff;
   // shared restoring divider, unsigned magnitudes
   word_type q_ff, r_ff, dvs_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic     qneg_ff, rneg_ff;

   word_type p0w, p1w, p2w, dmag, div_a, div_b;
   logic [DataWidth:0] rtrial;
   word_type q_sh, q_res, r_res;
   logic     n_gt_d;

   function automatic word_type mag(input word_type v);
      mag = v[DataWidth-1] ? (~v + 1'b1) : v;
   endfunction

   assign p0w    = word_type'(p0_ff);
   assign p1w    = word_type'(p1_ff);
   assign p2w    = word_type'(p2_ff);
   assign dmag   = mag(d_ff);
   assign n_gt_d = $signed(n_ff) > $signed(d_ff);
   assign rtrial = {r_ff, q_ff[DataWidth-1]} - {1'b0, dvs_ff};
   assign q_sh   = {q_ff[DataWidth-2:0], ~rtrial[DataWidth]};
   assign q_res  = qneg_ff ? (~q_sh + 1'b1) : q_sh;
   assign r_res  = rtrial[DataWidth] ? {r_ff[DataWidth-2:0], q_ff[DataWidth-1]}
                                     : rtrial[DataWidth-1:0];

   always_comb begin
      case (cmd.div_sel)
         DSEL_GCD:     begin div_a = ga_ff; div_b = gb_ff; end
         DSEL_RED_NUM: begin div_a = n_ff;  div_b = ga_ff; end
         DSEL_RED_DEN: begin div_a = d_ff;  div_b = ga_ff; end
         default:      begin div_a = n_ff;  div_b = d_ff;  end
      endcase
   end

   assign sts.n_pos    = !n_ff[DataWidth-1] && (n_ff != '0);
   assign sts.b_zero   = (gb_ff == '0);
   assign sts.div_last = (cnt_ff == CntWidth'(DataWidth - 1));
   assign sts.need_div = (n_ff != d_ff) && n_gt_d && (d_ff != '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         an_ff   <= req_a_num;
         ad_ff   <= req_a_den;
         bn_ff   <= req_b_num;
         bd_ff   <= req_b_den;
      end
      if (cmd.mul) begin
         p0_ff <= (func_ff == FUNC_MUL) ? an_ff * bn_ff : an_ff * bd_ff;
         p1_ff <= (func_ff == FUNC_DIV) ? ad_ff * bn_ff : ad_ff * bd_ff;
         p2_ff <= ad_ff * bn_ff;
      end
      if (cmd.sum) begin
         case (func_ff)
            FUNC_ADD: n_ff <= p0w + p2w;
            FUNC_SUB: n_ff <= p0w - p2w;
            default:  n_ff <= p0w;
         endcase
         d_ff <= p1w;
      end
      if (cmd.gcd_setup) begin
         ga_ff <= n_ff;
         gb_ff <= dmag;
      end
      if (cmd.div_start) begin
         q_ff    <= mag(div_a);
         r_ff    <= '0;
         dvs_ff  <= mag(div_b);
         cnt_ff  <= '0;
         qneg_ff <= div_a[DataWidth-1] ^ div_b[DataWidth-1];
         rneg_ff <= div_a[DataWidth-1];
      end else if (cmd.div_step) begin
         q_ff   <= q_sh;
         r_ff   <= r_res;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.gcd_step) begin
         ga_ff <= gb_ff;
         gb_ff <= r_res;
      end
      if (cmd.red_num) n_ff <= q_res;
      if (cmd.red_den) d_ff <= q_res;
      if (cmd.mix_eval) begin
         if (n_ff == d_ff) begin
            whole_ff <= word_type'(1);
            rem_ff   <= '0;
            dz_ff    <= 1'b0;
         end else if (n_gt_d) begin
            whole_ff <= '0;
            rem_ff   <= '0;
            dz_ff    <= (d_ff == '0);
         end else begin
            whole_ff <= '0;
            rem_ff   <= n_ff;
            dz_ff    <= 1'b0;
         end
      end
      if (cmd.mix_done) begin
         whole_ff <= q_res;
         rem_ff   <= rneg_ff ? (~r_res + 1'b1) : r_res;
      end
   end

   assign rsp_res_num    = n_ff;
   assign rsp_res_den    = d_ff;
   assign rsp_whole_part = whole_ff;
   assign rsp_frac_rem   = rem_ff;
   assign rsp_den_zero   = dz_ff;

endmodule
`default_nettype wire

@@ sv/rational_arithmetic_unit.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | func, a_num, a_den, b_num, b_den
// rsp     | out       | rsp_valid/rsp_stall  | res_num, res_den, whole_part, frac_rem, den_zero
// one beat at a time: load, products, then sum, then euclid gcd where each
// remainder takes one restoring divide on the shared divider, two more divides
// to reduce, and one for the mixed form when it needs a divide; a numerator that
// is not positive skips gcd and reduction; the next beat can be taken while
// rsp_valid is high if rsp_stall is low
// reset is synchronous and clears only the controller state and rsp_valid
// a result waits in the output registers while rsp_stall is high
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_func,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [DataWidth-1:0]          rsp_res_num,
   output logic signed [DataWidth-1:0]          rsp_res_den,
   output logic signed [DataWidth-1:0]          rsp_whole_part,
   output logic signed [DataWidth-1:0]          rsp_frac_rem,
   output logic                                 rsp_den_zero
);

   cmd_type    cmd;
   status_type sts;

   // sequencer: walks products, gcd loop, reduction and mixed form
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // multipliers, gcd registers and shared divider
   rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_whole_part (rsp_whole_part),
      .rsp_frac_rem   (rsp_frac_rem),
      .rsp_den_zero   (rsp_den_zero)
   );

   // a held result keeps its numerator and whole part
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_res_num) && $stable(rsp_whole_part), "result changed while held")
   // no new beat taken while a result is held
   `RAU_ASSERT_IMP(a_no_accept, clock, reset, rsp_valid && rsp_stall, req_stall,
      "input accepted over a held result")
   // den_zero only with zeroed mixed fields
   `RAU_ASSERT_IMP(a_dz_zero, clock, reset, rsp_valid && rsp_den_zero,
      (rsp_whole_part == '0) && (rsp_frac_rem == '0), "den_zero with nonzero mixed form")
   // an accepted beat starts the sequencer
   `RAU_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall,
      "not busy after accept")

endmodule
`default_nettype wire
